// ===== design/front_panel_command_link_assert.svh =====
// Assertion macros shared by the front-panel link checkers.
`ifndef FRONT_PANEL_COMMAND_LINK_ASSERT_SVH
`define FRONT_PANEL_COMMAND_LINK_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPCL_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("front_panel_command_link check failed");

// next-cycle implication
`define FPCL_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("front_panel_command_link check failed");

`endif

// ===== design/fpcl_pkg.sv =====
// Shared constants, codes and types of the front-panel command link.
package fpcl_pkg;

	localparam int STACK_DEPTH = 20;
	localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int STK_IDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;
	localparam int MS_W        = 10;
	localparam int TIME_W      = 32;

	localparam logic [1:0] REG_RUNNING   = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
	localparam logic [1:0] REG_LONGPRESS = 2'd2;
	localparam logic [1:0] REG_TRIGHOLD  = 2'd3;

	localparam logic [2:0] KIND_BYTE = 3'd0;
	localparam logic [2:0] KIND_TICK = 3'd1;
	localparam logic [2:0] KIND_LED0 = 3'd2;
	localparam logic [2:0] KIND_LED1 = 3'd3;
	localparam logic [2:0] KIND_TRIG = 3'd4;

	localparam logic [2:0] CLS_NONE  = 3'd0;
	localparam logic [2:0] CLS_REL   = 3'd1;
	localparam logic [2:0] CLS_PRS   = 3'd2;
	localparam logic [2:0] CLS_KNOBL = 3'd3;
	localparam logic [2:0] CLS_KNOBR = 3'd4;
	localparam logic [2:0] CLS_ERR   = 3'd5;

	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_DOWN     = 4'd1;
	localparam logic [3:0] EV_UP       = 4'd2;
	localparam logic [3:0] EV_UP_SHORT = 4'd3;
	localparam logic [3:0] EV_LONG     = 4'd4;
	localparam logic [3:0] EV_KNOBL    = 4'd5;
	localparam logic [3:0] EV_KNOBR    = 4'd6;
	localparam logic [3:0] EV_ERR      = 4'd7;
	localparam logic [3:0] EV_LATCHED  = 4'd8;

	localparam logic [7:0] CODE_CH0_ON   = 8'd129;
	localparam logic [7:0] CODE_CH0_OFF  = 8'd1;
	localparam logic [7:0] CODE_CH1_ON   = 8'd130;
	localparam logic [7:0] CODE_CH1_OFF  = 8'd2;
	localparam logic [7:0] CODE_TRIG_ON  = 8'd131;
	localparam logic [7:0] CODE_TRIG_OFF = 8'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] cls;
		logic [4:0] key;
		logic       enable;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} beat_t;

	typedef struct packed {
		logic            running;
		logic [MS_W-1:0] debounce;
		logic [MS_W-1:0] long_press;
		logic [MS_W-1:0] trig_hold;
	} cfg_t;

endpackage

// ===== design/fpcl_front.sv =====
// Front part: accepts input beats and classifies received panel bytes.
module fpcl_front (
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [2:0]     kind,
	input  logic [7:0]     command,
	input  logic           enable,
	input  logic           q_full,
	output fpcl_pkg::beat_t q_wr
);

	function automatic logic [2:0] classify(input logic [7:0] cmd);
		logic [2:0] c;
		c = fpcl_pkg::CLS_NONE;
		if (cmd inside {[8'd1:8'd18]})
			c = fpcl_pkg::CLS_REL;
		else if (cmd inside {[8'd129:8'd146]})
			c = fpcl_pkg::CLS_PRS;
		else if (cmd inside {[8'd20:8'd27]})
			c = fpcl_pkg::CLS_KNOBL;
		else if (cmd inside {[8'd148:8'd155]})
			c = fpcl_pkg::CLS_KNOBR;
		else if (cmd inside {[8'd28:8'd128], [8'd156:8'd255]})
			c = fpcl_pkg::CLS_ERR;
		return c;
	endfunction

	assign in_stall = q_full;

	always_comb begin
		q_wr.valid        = in_valid && !q_full;
		q_wr.entry.kind   = kind;
		q_wr.entry.cls    = (kind == fpcl_pkg::KIND_BYTE) ? classify(command) : fpcl_pkg::CLS_NONE;
		// key, knob number and right-knob low bits all sit in the low five bits
		q_wr.entry.key    = command[4:0];
		q_wr.entry.enable = enable;
	end

endmodule

// ===== design/fpcl_queue.sv =====
// Short queue between the classifying front and the executing back.
module fpcl_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  fpcl_pkg::beat_t wr,
	input  logic            pop,
	output fpcl_pkg::beat_t rd,
	output logic            full
);

	fpcl_pkg::entry_t mem_q [fpcl_pkg::QUEUE_DEPTH];
	logic [fpcl_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [fpcl_pkg::Q_CNT_W-1:0] cnt_q;
	logic do_pop;

	function automatic logic [fpcl_pkg::Q_PTR_W-1:0] nxt(input logic [fpcl_pkg::Q_PTR_W-1:0] p);
		logic [fpcl_pkg::Q_PTR_W-1:0] r;
		if (p == fpcl_pkg::Q_PTR_W'(fpcl_pkg::QUEUE_DEPTH - 1))
			r = '0;
		else
			r = p + 1'b1;
		return r;
	endfunction

	assign full     = (cnt_q == fpcl_pkg::Q_CNT_W'(fpcl_pkg::QUEUE_DEPTH));
	assign rd.valid = (cnt_q != '0);
	assign rd.entry = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd.valid;

	always_ff @(posedge clk) begin
		if (wr.valid)
			mem_q[wr_ptr_q] <= wr.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.valid)
				wr_ptr_q <= nxt(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= nxt(rd_ptr_q);
			if (wr.valid && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!wr.valid && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/fpcl_back.sv =====
// Back part: key/knob state, millisecond clock, LED send stack and result register.
module fpcl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fpcl_pkg::cfg_t  cfg,
	input  fpcl_pkg::beat_t rd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [3:0]      event_res,
	output logic [4:0]      target,
	output logic [7:0]      reply,
	output logic            trig_label,
	output logic            dropped
);

	localparam int TW = fpcl_pkg::TIME_W;
	localparam int CW = fpcl_pkg::STK_CNT_W;
	localparam int IW = fpcl_pkg::STK_IDX_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(fpcl_pkg::STACK_DEPTH);

	logic [TW-1:0] now_q, last_prs_q, last_rel_q, trig_time_q;
	logic [TW-1:0] now_nx, last_prs_nx, last_rel_nx, trig_time_nx;
	logic [4:0]    held_q, held_nx;
	logic [fpcl_pkg::MS_W-1:0] lc_q, lc_nx;
	logic          first_q, first_nx, lit_q, lit_nx;
	logic [7:0]    stack_q [fpcl_pkg::STACK_DEPTH];
	logic [CW-1:0] cnt_q, cnt_b, cnt_nx, cnt_m1;

	logic          out_valid_q, trig_q, drop_q;
	logic [3:0]    ev_q;
	logic [4:0]    tgt_q;
	logic [7:0]    reply_q;

	logic          fire;
	logic [3:0]    ev;
	logic [4:0]    tgt;
	logic [7:0]    rep;
	logic          drop;
	logic          rel_ok, prs_ok, lit0;
	logic [TW-1:0] tt0;
	logic          push1_v, push2_v, pop_v, a_ok, b_ok, pop_ok;
	logic [7:0]    push1_code, push2_code;
	fpcl_pkg::entry_t e;

	assign e    = rd.entry;
	assign fire = rd.valid && (!out_valid_q || !out_stall);
	assign pop  = fire;

	always_comb begin
		now_nx       = now_q;
		last_prs_nx  = last_prs_q;
		last_rel_nx  = last_rel_q;
		trig_time_nx = trig_time_q;
		held_nx      = held_q;
		lc_nx        = lc_q;
		first_nx     = first_q;
		lit_nx       = lit_q;
		ev           = fpcl_pkg::EV_NONE;
		tgt          = '0;
		push1_v      = 1'b0;
		push1_code   = '0;
		push2_v      = 1'b0;
		push2_code   = '0;
		pop_v        = 1'b0;
		lit0         = first_q ? 1'b0 : lit_q;
		tt0          = first_q ? now_q : trig_time_q;
		rel_ok = (e.cls == fpcl_pkg::CLS_REL) && ((now_q - last_rel_q) > TW'(cfg.debounce));
		prs_ok = (e.cls == fpcl_pkg::CLS_PRS) && ((now_q - last_prs_q) > TW'(cfg.debounce));
		case (e.kind)
			fpcl_pkg::KIND_BYTE: begin
				pop_v = 1'b1;
				if (rel_ok)
					last_rel_nx = now_q;
				if (prs_ok)
					last_prs_nx = now_q;
				if (!cfg.running) begin
					if (prs_ok) begin
						ev  = fpcl_pkg::EV_LATCHED;
						tgt = e.key;
					end
				end else if (rel_ok) begin
					ev      = (held_q != '0) ? fpcl_pkg::EV_UP_SHORT : fpcl_pkg::EV_UP;
					tgt     = e.key;
					held_nx = '0;
				end else if (prs_ok) begin
					ev      = fpcl_pkg::EV_DOWN;
					tgt     = e.key;
					held_nx = e.key;
					lc_nx   = cfg.long_press;
				end else if (e.cls == fpcl_pkg::CLS_KNOBL) begin
					ev  = fpcl_pkg::EV_KNOBL;
					tgt = e.key;
				end else if (e.cls == fpcl_pkg::CLS_KNOBR) begin
					ev  = fpcl_pkg::EV_KNOBR;
					tgt = e.key;
				end else if (e.cls == fpcl_pkg::CLS_ERR) begin
					ev = fpcl_pkg::EV_ERR;
				end
			end
			fpcl_pkg::KIND_TICK: begin
				now_nx = now_q + 1'b1;
				if (lc_q != '0) begin
					lc_nx = lc_q - 1'b1;
					if (lc_q == fpcl_pkg::MS_W'(1) && held_q != '0) begin
						ev      = fpcl_pkg::EV_LONG;
						tgt     = held_q;
						held_nx = '0;
					end
				end
			end
			fpcl_pkg::KIND_LED0: begin
				push2_v    = 1'b1;
				push2_code = e.enable ? fpcl_pkg::CODE_CH0_ON : fpcl_pkg::CODE_CH0_OFF;
			end
			fpcl_pkg::KIND_LED1: begin
				push2_v    = 1'b1;
				push2_code = e.enable ? fpcl_pkg::CODE_CH1_ON : fpcl_pkg::CODE_CH1_OFF;
			end
			fpcl_pkg::KIND_TRIG: begin
				// first update forces the LED off before handling enable
				push1_v      = first_q;
				push1_code   = fpcl_pkg::CODE_TRIG_OFF;
				first_nx     = 1'b0;
				lit_nx       = lit0;
				trig_time_nx = e.enable ? now_q : tt0;
				if (e.enable != lit0) begin
					if (e.enable) begin
						push2_v    = 1'b1;
						push2_code = fpcl_pkg::CODE_TRIG_ON;
						lit_nx     = 1'b1;
					end else if ((now_q - tt0) > TW'(cfg.trig_hold)) begin
						push2_v    = 1'b1;
						push2_code = fpcl_pkg::CODE_TRIG_OFF;
						lit_nx     = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// stack: up to two pushes or one pop per beat
	always_comb begin
		a_ok   = push1_v && (cnt_q < DEPTH_C);
		cnt_b  = cnt_q + CW'(a_ok);
		b_ok   = push2_v && (cnt_b < DEPTH_C);
		drop   = (push1_v && !a_ok) || (push2_v && !b_ok);
		pop_ok = pop_v && (cnt_q != '0);
		cnt_m1 = cnt_q - 1'b1;
		rep    = pop_ok ? stack_q[cnt_m1[IW-1:0]] : 8'd0;
		cnt_nx = pop_ok ? cnt_m1 : (cnt_b + CW'(b_ok));
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (a_ok)
				stack_q[cnt_q[IW-1:0]] <= push1_code;
			if (b_ok)
				stack_q[cnt_b[IW-1:0]] <= push2_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			last_prs_q  <= '0;
			last_rel_q  <= '0;
			trig_time_q <= '0;
			held_q      <= '0;
			lc_q        <= '0;
			first_q     <= 1'b1;
			lit_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				now_q       <= now_nx;
				last_prs_q  <= last_prs_nx;
				last_rel_q  <= last_rel_nx;
				trig_time_q <= trig_time_nx;
				held_q      <= held_nx;
				lc_q        <= lc_nx;
				first_q     <= first_nx;
				lit_q       <= lit_nx;
				cnt_q       <= cnt_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ev_q    <= ev;
			tgt_q   <= tgt;
			reply_q <= rep;
			trig_q  <= lit_nx;
			drop_q  <= drop;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = ev_q;
	assign target     = tgt_q;
	assign reply      = reply_q;
	assign trig_label = trig_q;
	assign dropped    = drop_q;

endmodule

// ===== design/front_panel_command_link.sv =====
// Top level of the front-panel command link: APB registers, front, queue and back.
// Path: an accepted beat is written into the queue, popped by the back part and registered in its result register.
// Throughput: one beat per cycle; the back part retires one queued beat each cycle
// the result register is free or being taken. in_stall rises only when the 4-deep queue fills.
// Reset (arst_n low, asynchronous): queue and stack empty, clock and timers zero,
// registers back to running=1, debounce 100, long press 500, trig hold 100.
module front_panel_command_link (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        kind,
	input  logic [7:0]                        command,
	input  logic                              enable,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [3:0]                        event_res,
	output logic [4:0]                        target,
	output logic [7:0]                        reply,
	output logic                              trig_label,
	output logic                              dropped,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fpcl_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [fpcl_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [fpcl_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int DW = fpcl_pkg::APB_DATA_W;

	fpcl_pkg::cfg_t  cfg_q;
	fpcl_pkg::beat_t q_wr, q_rd;
	logic            q_full, q_pop, wr_en;
	logic [1:0]      reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.running    <= 1'b1;
			cfg_q.debounce   <= fpcl_pkg::MS_W'(100);
			cfg_q.long_press <= fpcl_pkg::MS_W'(500);
			cfg_q.trig_hold  <= fpcl_pkg::MS_W'(100);
		end else if (wr_en) begin
			case (reg_idx)
				fpcl_pkg::REG_RUNNING:   cfg_q.running    <= pwdata[0];
				fpcl_pkg::REG_DEBOUNCE:  cfg_q.debounce   <= pwdata[fpcl_pkg::MS_W-1:0];
				fpcl_pkg::REG_LONGPRESS: cfg_q.long_press <= pwdata[fpcl_pkg::MS_W-1:0];
				fpcl_pkg::REG_TRIGHOLD:  cfg_q.trig_hold  <= pwdata[fpcl_pkg::MS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fpcl_pkg::REG_RUNNING:   prdata = DW'(cfg_q.running);
			fpcl_pkg::REG_DEBOUNCE:  prdata = DW'(cfg_q.debounce);
			fpcl_pkg::REG_LONGPRESS: prdata = DW'(cfg_q.long_press);
			fpcl_pkg::REG_TRIGHOLD:  prdata = DW'(cfg_q.trig_hold);
			default:                 prdata = '0;
		endcase
	end

	fpcl_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.command  (command),
		.enable   (enable),
		.q_full   (q_full),
		.q_wr     (q_wr)
	);

	fpcl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.full   (q_full)
	);

	fpcl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.rd         (q_rd),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.target     (target),
		.reply      (reply),
		.trig_label (trig_label),
		.dropped    (dropped)
	);

endmodule

// ===== design/fpcl_checker.sv =====
// Port-level checker for the front-panel command link, bound to the top level.
`include "front_panel_command_link_assert.svh"

module fpcl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] event_res,
	input logic [4:0] target,
	input logic [7:0] reply,
	input logic       dropped
);

	`FPCL_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_res) && $stable(target) && $stable(reply))
	`FPCL_ASSERT_IMP(a_no_target, out_valid && (event_res == fpcl_pkg::EV_NONE || event_res == fpcl_pkg::EV_ERR), target == 5'd0)
	`FPCL_ASSERT_IMP(a_drop_quiet, out_valid && dropped, event_res == fpcl_pkg::EV_NONE && reply == 8'd0)
	`FPCL_ASSERT_IMP(a_key_range, out_valid && (event_res == fpcl_pkg::EV_DOWN || event_res == fpcl_pkg::EV_UP || event_res == fpcl_pkg::EV_UP_SHORT || event_res == fpcl_pkg::EV_LONG || event_res == fpcl_pkg::EV_LATCHED), target >= 5'd1 && target <= 5'd18)

endmodule

bind front_panel_command_link fpcl_checker u_fpcl_checker (.*);
